@@ rtl/core/hgcd_pkg.sv @@
// Shared constants, fixed-point formats and the arctangent table for the
// haversine distance pipeline. No dependencies.
package hgcd_pkg;

    // Angle scaling: the port widths below are sized for this many fraction bits
    localparam int ANGLE_FRAC_BITS = 20;

    // Parameter defaults
    localparam int CORDIC_STAGES_DEF   = 24;

    // Port field widths
    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 25;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
    localparam logic [DIST_W-1:0]   DIST_MAX     = 25'd26353424;

    // Q30 unit values (0 .. 2^30) need 31 bits
    localparam int UNIT_W = 31;
    localparam logic [UNIT_W-1:0] ONE_Q30 = 31'd1073741824;

    // CORDIC datapath width, signed
    localparam int CW = 34;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30  = 34'sd1686629714;

    // Degrees to radians, pi/180 in Q32
    localparam int K_W = 27;
    localparam logic [K_W-1:0] DEG2RAD_Q32 = 27'd74961321;

    // Angle magnitude width after clamping and wrap
    localparam int MAG_W = 30;

    // Bitwise square root: 31 result bits from a 61-bit radicand
    localparam int SQ_STEPS = 31;
    localparam int SQ_VW    = 61;
    localparam int SQ_RW    = 62;

    // atan(2^-i) in Q30, rounded half up
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd1
    };

endpackage

@@ rtl/core/hgcd_if.sv @@
// Channel interfaces: point-pair input, distance output, radius write.
// Depends on hgcd_pkg for field widths.
interface hgcd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hgcd_pkg::LAT_W-1:0]   lat_a;
    logic signed [hgcd_pkg::LON_W-1:0]   lon_a;
    logic signed [hgcd_pkg::LAT_W-1:0]   lat_b;
    logic signed [hgcd_pkg::LON_W-1:0]   lon_b;
    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hgcd_out_if;
    logic                            valid;
    logic                            ready;
    logic [hgcd_pkg::DIST_W-1:0]     distance_m;
    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

interface hgcd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hgcd_pkg::RADIUS_W-1:0]   earth_radius_m;
    modport source (output valid, earth_radius_m, input ready);
    modport sink   (input valid, earth_radius_m, output ready);
endinterface

@@ rtl/core/hgcd_rotate.sv @@
// Pipelined rotation-mode CORDIC, one iteration per stage; gives clamped
// cosine and sine in Q30. Depends on hgcd_pkg.
module hgcd_rotate #(
    parameter int STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [hgcd_pkg::CW-1:0]    i_z,
    output logic [hgcd_pkg::UNIT_W-1:0]       o_cos,
    output logic [hgcd_pkg::UNIT_W-1:0]       o_sin
);
    import hgcd_pkg::*;

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];

    // One micro-rotation per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [CW-1:0] px, py, pz, t;
        logic signed [CW-1:0] n_x, n_y, n_z;
        always_comb begin
            if (g == 0) begin
                px = INV_GAIN_Q30;
                py = '0;
                pz = i_z;
            end else begin
                px = r_x[(g == 0) ? 0 : g-1];
                py = r_y[(g == 0) ? 0 : g-1];
                pz = r_z[(g == 0) ? 0 : g-1];
            end
            t = CW'(ATAN_Q30[g]);
            if (!pz[CW-1]) begin
                n_x = px - (py >>> g);
                n_y = py + (px >>> g);
                n_z = pz - t;
            end else begin
                n_x = px + (py >>> g);
                n_y = py - (px >>> g);
                n_z = pz + t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    // Clamp to [0, 1]
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        if (v[CW-1])
            return '0;
        else if (v > CW'(ONE_Q30))
            return ONE_Q30;
        else
            return v[UNIT_W-1:0];
    endfunction

    assign o_cos = clamp_unit(r_x[STAGES-1]);
    assign o_sin = clamp_unit(r_y[STAGES-1]);

endmodule

@@ rtl/core/hgcd_sqrt.sv @@
// Pipelined bitwise integer square root, one result bit per stage.
// Depends on hgcd_pkg.
module hgcd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hgcd_pkg::SQ_VW-1:0]    i_v,
    output logic [hgcd_pkg::UNIT_W-1:0]   o_root
);
    import hgcd_pkg::*;

    logic [SQ_RW-1:0] r_v [SQ_STEPS];
    logic [SQ_RW-1:0] r_r [SQ_STEPS];

    // Trial subtract of r + bit, bit walking down by two places
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        localparam logic [SQ_RW-1:0] BIT = SQ_RW'(1) << (2 * (SQ_STEPS - 1 - g));
        logic [SQ_RW-1:0] pv, pr, tr, n_v, n_r;
        always_comb begin
            if (g == 0) begin
                pv = SQ_RW'(i_v);
                pr = '0;
            end else begin
                pv = r_v[(g == 0) ? 0 : g-1];
                pr = r_r[(g == 0) ? 0 : g-1];
            end
            tr = pr + BIT;
            if (pv >= tr) begin
                n_v = pv - tr;
                n_r = (pr >> 1) + BIT;
            end else begin
                n_v = pv;
                n_r = pr >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= n_v;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_root = r_r[SQ_STEPS-1][UNIT_W-1:0];

endmodule

@@ rtl/core/hgcd_vector.sv @@
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in Q30, clamped to
// [0, pi/2]. Depends on hgcd_pkg.
module hgcd_vector #(
    parameter int STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [hgcd_pkg::UNIT_W-1:0]       i_x,
    input  logic [hgcd_pkg::UNIT_W-1:0]       i_y,
    output logic signed [hgcd_pkg::CW-1:0]    o_angle
);
    import hgcd_pkg::*;

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];

    // Drive y toward zero, accumulate the angle
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [CW-1:0] px, py, pz, t;
        logic signed [CW-1:0] n_x, n_y, n_z;
        always_comb begin
            if (g == 0) begin
                px = signed'(CW'(i_x));
                py = signed'(CW'(i_y));
                pz = '0;
            end else begin
                px = r_x[(g == 0) ? 0 : g-1];
                py = r_y[(g == 0) ? 0 : g-1];
                pz = r_z[(g == 0) ? 0 : g-1];
            end
            t = CW'(ATAN_Q30[g]);
            if (py > 0) begin
                n_x = px + (py >>> g);
                n_y = py - (px >>> g);
                n_z = pz + t;
            end else begin
                n_x = px - (py >>> g);
                n_y = py + (px >>> g);
                n_z = pz - t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    always_comb begin
        if (r_z[STAGES-1][CW-1])
            o_angle = '0;
        else if (r_z[STAGES-1] > HALF_PI_Q30)
            o_angle = HALF_PI_Q30;
        else
            o_angle = r_z[STAGES-1];
    end

endmodule

@@ rtl/core/haversine_great_circle_distance_unit.sv @@
// Haversine great-circle distance: one point pair per cycle in, one distance
// per cycle out; the path runs through two CORDIC pipelines and a 31-stage
// square root. The whole pipeline advances while the output register is empty
// or its beat is taken; an output stall holds every stage.
// The radius register is written through the config channel, always ready.
// Depends on hgcd_pkg, hgcd_if, hgcd_rotate, hgcd_sqrt, hgcd_vector.
module haversine_great_circle_distance_unit #(
    parameter int CORDIC_STAGES   = hgcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hgcd_in_if.sink           i_pair,
    hgcd_cfg_if.sink          i_cfg,
    hgcd_out_if.source        o_dist
);
    import hgcd_pkg::*;

    localparam int WW  = 34;
    localparam int LAT = 2 * CORDIC_STAGES + 40;
    localparam int PW  = MAG_W + K_W + 1;
    localparam logic signed [WW-1:0] LAT_LIM = WW'(90) << ANGLE_FRAC_BITS;
    localparam logic signed [WW-1:0] LON_LIM = WW'(180) << ANGLE_FRAC_BITS;

    logic                  adv;
    logic [LAT-1:0]        r_vld;
    logic [RADIUS_W-1:0]   r_radius;

    // Global advance: output empty or being taken
    assign adv          = !r_vld[LAT-1] || o_dist.ready;
    assign i_pair.ready = adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (adv) r_vld <= {r_vld[LAT-2:0], i_pair.valid};
            if (i_cfg.valid) r_radius <= i_cfg.earth_radius_m;
        end
    end

    function automatic logic signed [WW-1:0] clamp_sym(
        input logic signed [WW-1:0] v, input logic signed [WW-1:0] lim);
        if (v > lim) return lim;
        else if (v < -lim) return -lim;
        else return v;
    endfunction

    function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] v);
        return v[WW-1] ? WW'(-v) : WW'(v);
    endfunction

    // Stage 1: clamp, differences, magnitudes, longitude wrap
    logic signed [WW-1:0] la, oa, lb, ob;
    logic [WW-1:0]        dlat, dlon_raw, dlon, la_mag, lb_mag;
    logic [MAG_W-1:0]     r_mag [4];

    always_comb begin
        la       = clamp_sym(WW'(i_pair.lat_a), LAT_LIM);
        oa       = clamp_sym(WW'(i_pair.lon_a), LON_LIM);
        lb       = clamp_sym(WW'(i_pair.lat_b), LAT_LIM);
        ob       = clamp_sym(WW'(i_pair.lon_b), LON_LIM);
        dlat     = mag(lb - la);
        dlon_raw = mag(ob - oa);
        la_mag   = mag(la);
        lb_mag   = mag(lb);
        if (dlon_raw > WW'(LON_LIM))
            dlon = WW'(LON_LIM <<< 1) - dlon_raw;
        else
            dlon = dlon_raw;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mag[0] <= dlat[MAG_W-1:0];
            r_mag[1] <= dlon[MAG_W-1:0];
            r_mag[2] <= la_mag[MAG_W-1:0];
            r_mag[3] <= lb_mag[MAG_W-1:0];
        end
    end

    // Stages 2 and 3: degrees to radians, half angles for the differences
    logic [PW-1:0]        r_prod [4];
    logic signed [CW-1:0] r_ang  [4];

    for (genvar k = 0; k < 4; k++) begin : g_rad
        localparam int SH = ANGLE_FRAC_BITS + ((k < 2) ? 3 : 2);
        logic [PW-1:0] rounded;
        assign rounded = r_prod[k] + (PW'(1) << (SH - 1));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_prod[k] <= PW'(r_mag[k]) * PW'(DEG2RAD_Q32);
                r_ang[k]  <= signed'(CW'(rounded >> SH));
            end
        end
    end

    // Rotation CORDICs: sin(dlat/2), sin(dlon/2), cos(lat_a), cos(lat_b)
    logic [UNIT_W-1:0] s1, s2, c1, c2;

    hgcd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
        .i_clk(i_clk), .i_en(adv), .i_z(r_ang[0]), .o_cos(), .o_sin(s1));
    hgcd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
        .i_clk(i_clk), .i_en(adv), .i_z(r_ang[1]), .o_cos(), .o_sin(s2));
    hgcd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_lata (
        .i_clk(i_clk), .i_en(adv), .i_z(r_ang[2]), .o_cos(c1), .o_sin());
    hgcd_rotate #(.STAGES(CORDIC_STAGES)) u_rot_latb (
        .i_clk(i_clk), .i_en(adv), .i_z(r_ang[3]), .o_cos(c2), .o_sin());

    // Products for a, rounded Q30; each product is registered before it is rounded
    localparam int MW = 2 * UNIT_W;
    localparam logic [MW-1:0] HALF_LSB = MW'(1) << 29;
    logic [MW-1:0]       r_p_ss1, r_p_cc, r_p_ss2, r_p_a2;
    logic [UNIT_W-1:0]   r_q_ss1, r_q_cc, r_q_ss2, r_q_ss1_d;
    logic [MW-1:0]       rnd_ss1, rnd_cc, rnd_ss2, rnd_a2;
    logic [UNIT_W:0]     a_sum;
    logic [UNIT_W-1:0]   r_a;

    assign rnd_ss1 = (r_p_ss1 + HALF_LSB) >> 30;
    assign rnd_cc  = (r_p_cc + HALF_LSB) >> 30;
    assign rnd_ss2 = (r_p_ss2 + HALF_LSB) >> 30;
    assign rnd_a2  = (r_p_a2 + HALF_LSB) >> 30;
    assign a_sum   = (UNIT_W+1)'(r_q_ss1_d) + (UNIT_W+1)'(rnd_a2[UNIT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_ss1   <= MW'(s1) * MW'(s1);
            r_p_cc    <= MW'(c1) * MW'(c2);
            r_p_ss2   <= MW'(s2) * MW'(s2);
            r_q_ss1   <= rnd_ss1[UNIT_W-1:0];
            r_q_cc    <= rnd_cc[UNIT_W-1:0];
            r_q_ss2   <= rnd_ss2[UNIT_W-1:0];
            r_p_a2    <= MW'(r_q_cc) * MW'(r_q_ss2);
            r_q_ss1_d <= r_q_ss1;
            r_a       <= (a_sum > (UNIT_W+1)'(ONE_Q30)) ? ONE_Q30 : a_sum[UNIT_W-1:0];
        end
    end

    // Square roots of a and 1-a
    logic [UNIT_W-1:0] sy, sx;
    logic [UNIT_W-1:0] one_minus_a;
    assign one_minus_a = ONE_Q30 - r_a;

    hgcd_sqrt u_sqrt_a (
        .i_clk(i_clk), .i_en(adv), .i_v({r_a, 30'd0}), .o_root(sy));
    hgcd_sqrt u_sqrt_1ma (
        .i_clk(i_clk), .i_en(adv), .i_v({one_minus_a, 30'd0}), .o_root(sx));

    // Central half angle
    logic signed [CW-1:0] z;
    hgcd_vector #(.STAGES(CORDIC_STAGES)) u_atan (
        .i_clk(i_clk), .i_en(adv), .i_x(sx), .i_y(sy), .o_angle(z));

    // Scale by radius, round, saturate
    localparam int DPW = RADIUS_W + 32;
    logic [DPW-1:0]    r_dprod, drnd;
    logic [DIST_W-1:0] r_dist;

    assign drnd = (r_dprod + (DPW'(1) << 29)) >> 30;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dprod <= DPW'(r_radius) * DPW'({z[30:0], 1'b0});
            r_dist  <= (drnd > DPW'(DIST_MAX)) ? DIST_MAX : drnd[DIST_W-1:0];
        end
    end

    assign o_dist.valid      = r_vld[LAT-1];
    assign o_dist.distance_m = r_dist;

`ifndef SYNTH
    // Input is taken exactly when the pipeline moves
    a_ready_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pair.ready == (!o_dist.valid || o_dist.ready))
        else $error("input ready disagrees with output stall");

    // A stall freezes the valid chain
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid chain moved during a stall");

    // a never exceeds one for a live beat
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[CORDIC_STAGES+6] |-> (r_a <= ONE_Q30))
        else $error("a exceeds one");

    // Delivered distance within range
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.valid |-> (o_dist.distance_m <= DIST_MAX))
        else $error("distance above saturation limit");
`endif

endmodule
